/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at each rising edge, also while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/kwm_pkg.sv */
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int LISTS_DEF      = 8;
  localparam int LIST_DEPTH_DEF = 64;

  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] list_index;
    value_t             value;
  } in_item_t;

  typedef struct packed {
    value_t              out_value;
    logic [INDEX_W-1:0]  source_list;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_POP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PTR_NOP,
    PTR_PUSH,
    PTR_POP,
    PTR_CLEAR
  } ptr_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ptr_stat_t;

endpackage

/* sv/kwm_list_mem.sv */
`timescale 1ns / 1ps

module kwm_list_mem import kwm_pkg::*; #(
  parameter int LISTS      = LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int WORDS     = LISTS * LIST_DEPTH,
  localparam int ADDR_W    = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  value_t            wdata,
  output value_t            rdata
);

  value_t mem_r [WORDS];
  value_t rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/kwm_ptr_file.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kwm_ptr_file import kwm_pkg::*; #(
  parameter int LISTS      = LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int LW        = $clog2(LISTS),
  localparam int PTR_W     = $clog2(LIST_DEPTH),
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptr_op_t          op,
  input  logic [LW-1:0]    idx,
  output logic [PTR_W-1:0] head,
  output logic [PTR_W-1:0] tail,
  output ptr_stat_t        stat
);

  logic [PTR_W-1:0] head_r [LISTS];
  logic [CNT_W-1:0] fill_r [LISTS];

  logic [CNT_W-1:0] fill_rd;
  logic [CNT_W:0]   sum;
  logic [PTR_W-1:0] head_nxt;

  assign head    = head_r[idx];
  assign fill_rd = fill_r[idx];

  // tail = head + fill, wrapped once around the ring
  assign sum  = (CNT_W+1)'(head) + (CNT_W+1)'(fill_rd);
  assign tail = (sum >= (CNT_W+1)'(LIST_DEPTH)) ? PTR_W'(sum - (CNT_W+1)'(LIST_DEPTH))
                                                 : PTR_W'(sum);

  assign head_nxt = (head == PTR_W'(LIST_DEPTH - 1)) ? '0 : head + 1'b1;

  assign stat.full  = (fill_rd == CNT_W'(LIST_DEPTH));
  assign stat.empty = (fill_rd == '0);

  always_ff @(posedge clk) begin
    if (!rst_n || op == PTR_CLEAR) begin
      for (int i = 0; i < LISTS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      case (op)
        PTR_PUSH: begin
          fill_r[idx] <= fill_rd + 1'b1;
        end
        PTR_POP: begin
          head_r[idx] <= head_nxt;
          fill_r[idx] <= fill_rd - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_CLK(a_push_not_full, (op == PTR_PUSH) |-> !stat.full, "push to a full list")
  `ASSERT_CLK(a_pop_not_empty, (op == PTR_POP) |-> !stat.empty, "pop from an empty list")

endmodule

/* sv/kwm_min_unit.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kwm_min_unit import kwm_pkg::*; #(
  parameter int LISTS = LISTS_DEF,
  localparam int LW   = $clog2(LISTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cmp_en,
  input  value_t        cand_val,
  input  logic [LW-1:0] cand_idx,
  output logic          found,
  output value_t        best_val,
  output logic [LW-1:0] best_idx
);

  logic          found_r;
  value_t        best_val_r;
  logic [LW-1:0] best_idx_r;
  logic          take;

  // strict less-than: on a tie the earlier (lower numbered) list stays
  assign take = cmp_en && (!found_r || (cand_val < best_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_val_r <= cand_val;
      best_idx_r <= cand_idx;
    end
  end

  assign found    = found_r;
  assign best_val = best_val_r;
  assign best_idx = best_idx_r;

  `ASSERT_CLK(a_min_never_rises, found_r && !start |=> best_val_r <= $past(best_val_r), "running min rose")

endmodule

/* sv/k_way_sorted_merge.sv */
`timescale 1ns / 1ps
// k-way sorted merge over LISTS ring-buffer lists of signed 32-bit values.
// Input channel (in_valid/in_ready/in_item): a load appends in_item.value to
// list in_item.list_index, a take pops the smallest head over all lists
// (lowest list number on a tie), a clear empties every list.
// Output channel (out_valid/out_ready/out_item): exactly one result per item,
// carrying the taken value, its list number and a status (ok, full, empty).
// One item is in work at a time; in_ready is high only while idle.
// States an item passes from one transfer in to the next, with the output free:
//   load: LOAD, DONE; clear or unused kind: DONE; take: SCAN, POP, DONE.
// A take walks the lists one per cycle through a single signed comparator,
// fed by the one port of the list memory, so its time grows with LISTS.
// Results sit in an output register: a new item is taken while a result
// waits, and its own result holds in the block until out_ready frees it.
// Reset (synchronous, rst_n low) empties every list and drops any result;
// the list memory itself is not cleared and needs no sweep.

`include "assert_macros.svh"

module k_way_sorted_merge import kwm_pkg::*; #(
  parameter int LISTS      = LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int LW     = $clog2(LISTS);
  localparam int SCAN_W = LW + 1;
  localparam int PTR_W  = $clog2(LIST_DEPTH);
  localparam int ADDR_W = $clog2(LISTS * LIST_DEPTH);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [SCAN_W-1:0] cnt_r, cnt_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [LW-1:0]     pend_idx_r, pend_idx_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_item_r, out_item_nxt;

  ptr_op_t           ptr_op;
  logic [LW-1:0]     ptr_idx;
  logic [PTR_W-1:0]  ptr_head;
  logic [PTR_W-1:0]  ptr_tail;
  ptr_stat_t         ptr_stat;

  logic              mem_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  value_t            mem_rdata;

  logic              min_start;
  logic              min_found;
  value_t            min_val;
  logic [LW-1:0]     min_idx;

  logic              idx_ok;

  assign idx_ok = (32'(item_r.list_index) < LISTS);

  // list base plus ring position; loads write at the tail, takes read heads
  assign mem_addr = ADDR_W'(ptr_idx) * ADDR_W'(LIST_DEPTH)
                  + ADDR_W'((state_r == S_LOAD) ? ptr_tail : ptr_head);

  kwm_ptr_file #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (ptr_op),
    .idx   (ptr_idx),
    .head  (ptr_head),
    .tail  (ptr_tail),
    .stat  (ptr_stat)
  );

  kwm_list_mem #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (item_r.value),
    .rdata (mem_rdata)
  );

  kwm_min_unit #(
    .LISTS (LISTS)
  ) u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (min_start),
    .cmp_en   (pend_vld_r),
    .cand_val (mem_rdata),
    .cand_idx (pend_idx_r),
    .found    (min_found),
    .best_val (min_val),
    .best_idx (min_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = 1'b0;
    pend_idx_nxt = pend_idx_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_item_nxt = out_item_r;
    in_ready     = 1'b0;
    ptr_op       = PTR_NOP;
    ptr_idx      = LW'(item_r.list_index);
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    min_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_item;
          res_nxt  = '0;
          case (in_item.kind)
            KIND_LOAD: begin
              state_nxt = S_LOAD;
            end
            KIND_TAKE: begin
              cnt_nxt   = '0;
              min_start = 1'b1;
              state_nxt = S_SCAN;
            end
            KIND_CLEAR: begin
              ptr_op    = PTR_CLEAR;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_LOAD: begin
        if (!idx_ok || ptr_stat.full) begin
          res_nxt.status = STATUS_FULL;
        end else begin
          mem_en = 1'b1;
          mem_we = 1'b1;
          ptr_op = PTR_PUSH;
        end
        state_nxt = S_DONE;
      end

      // one list per cycle: issue the head read now, compare it next cycle
      S_SCAN: begin
        ptr_idx = cnt_r[LW-1:0];
        if (cnt_r == SCAN_W'(LISTS)) begin
          state_nxt = S_POP;
        end else begin
          mem_en       = !ptr_stat.empty;
          pend_vld_nxt = !ptr_stat.empty;
          pend_idx_nxt = cnt_r[LW-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end
      end

      S_POP: begin
        ptr_idx = min_idx;
        if (min_found) begin
          ptr_op              = PTR_POP;
          res_nxt.out_value   = min_val;
          res_nxt.source_list = INDEX_W'(min_idx);
          res_nxt.status      = STATUS_OK;
        end else begin
          res_nxt.status = STATUS_EMPTY;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt  = 1'b1;
          out_item_nxt = res_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `ASSERT_CLK(a_one_item_in_work, in_valid && in_ready |=> !in_ready, "second transfer while busy")

endmodule

/* tb/sv/kwm_merge_checker.sv */
`timescale 1ns / 1ps

module kwm_merge_checker import kwm_pkg::*; #(
  parameter int LISTS      = LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        errors,
  output int        pending
);

  localparam int POS_W  = $clog2(LIST_DEPTH);
  localparam int FILL_W = $clog2(LIST_DEPTH + 1);

  value_t            list_mem [LISTS][LIST_DEPTH];
  logic [POS_W-1:0]  head_pos [LISTS];
  logic [FILL_W-1:0] fill_cnt [LISTS];
  out_item_t         expected_results [$];
  int                fail_cnt = 0;

  // Applies one item to the shadow lists and returns the result it must produce.
  function automatic out_item_t merge_step(input in_item_t it);
    out_item_t res;
    int        idx;
    int        slot;
    int        best;
    value_t    head;
    res  = '0;
    idx  = int'(it.list_index);
    best = -1;
    head = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (idx >= LISTS || fill_cnt[idx] >= LIST_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          slot = int'(head_pos[idx]) + int'(fill_cnt[idx]);
          if (slot >= LIST_DEPTH) slot -= LIST_DEPTH;
          list_mem[idx][slot] = it.value;
          fill_cnt[idx]++;
        end
      end
      KIND_TAKE: begin
        // strict less-than keeps the lowest list on equal heads
        for (int i = 0; i < LISTS; i++) begin
          if (fill_cnt[i] != 0 && (best < 0 || list_mem[i][head_pos[i]] < head)) begin
            best = i;
            head = list_mem[i][head_pos[i]];
          end
        end
        if (best < 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value   = head;
          res.source_list = INDEX_W'(best);
          if (int'(head_pos[best]) == LIST_DEPTH - 1) head_pos[best] = '0;
          else head_pos[best] = head_pos[best] + 1'b1;
          fill_cnt[best]--;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < LISTS; i++) begin
          head_pos[i] = '0;
          fill_cnt[i] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < LISTS; i++) begin
        head_pos[i] = '0;
        fill_cnt[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with nothing expected: value=%0d list=%0d status=%0d",
                     $realtime, out_item.out_value, out_item.source_list, out_item.status);
        end else begin
          want = expected_results.pop_front();
          if (out_item.out_value !== want.out_value ||
              out_item.source_list !== want.source_list ||
              out_item.status !== want.status) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch: expected value=%0d list=%0d status=%0d, got value=%0d list=%0d status=%0d",
                       $realtime, want.out_value, want.source_list, want.status,
                       out_item.out_value, out_item.source_list, out_item.status);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(merge_step(in_item));
    end
    errors  <= fail_cnt;
    pending <= expected_results.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import kwm_pkg::*;

  localparam int ITEM_TARGET = 550;
  localparam int CALM_ITEMS  = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        errors;
  int        pending;
  int        items_sent   = 0;
  int        send_gap_pct = 20;
  bit        calm         = 1'b0;

  always #6 clk = ~clk;

  k_way_sorted_merge DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  kwm_merge_checker merge_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .errors   (errors),
    .pending  (pending)
  );

  function automatic in_item_t item_of(input logic [KIND_W-1:0] kind, input int idx,
                                       input value_t val);
    in_item_t it;
    it.kind       = kind;
    it.list_index = INDEX_W'(idx);
    it.value      = val;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering and wait until every outstanding result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ascending loads spread over random lists, then takes to merge them out.
  task automatic merge_run();
    value_t tail [LISTS_DEF];
    longint nxt;
    int     loads;
    int     lst;
    bit     tie_mode;
    tie_mode = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1)) send_item(item_of(KIND_CLEAR, $urandom_range(0, 7), $urandom));
    for (int i = 0; i < LISTS_DEF; i++)
      tail[i] = tie_mode ? value_t'($urandom_range(0, 2)) : value_t'($urandom);
    loads = $urandom_range(2, 24);
    for (int n = 0; n < loads; n++) begin
      lst = $urandom_range(0, LISTS_DEF - 1);
      nxt = longint'(tail[lst]) +
            (tie_mode ? longint'($urandom_range(0, 1)) : longint'($urandom_range(0, 1 << 28)));
      if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
      tail[lst] = value_t'(nxt);
      send_item(item_of(KIND_LOAD, lst, tail[lst]));
    end
    repeat (loads + $urandom_range(0, 2))
      send_item(item_of(KIND_TAKE, $urandom_range(0, 7), $urandom));
  endtask

  task automatic noise_run();
    repeat ($urandom_range(1, 8))
      send_item(item_of(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom));
  endtask

  // One list filled past its depth, partly drained, refilled across the wrap.
  task automatic fill_run();
    int lst;
    lst = $urandom_range(0, 7);
    send_item(item_of(KIND_CLEAR, 0, 0));
    repeat (LIST_DEPTH_DEF + 1) send_item(item_of(KIND_LOAD, lst, $urandom));
    repeat (10) send_item(item_of(KIND_TAKE, lst, $urandom));
    repeat (12) send_item(item_of(KIND_LOAD, lst, $urandom));
    repeat (LIST_DEPTH_DEF + 1) send_item(item_of(KIND_TAKE, lst, $urandom));
  endtask

  initial begin : stimulus
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_item(item_of(KIND_TAKE, 0, 0));
    send_item(item_of(KIND_UNUSED, 7, 32'hFFFF_FFFF));
    send_item(item_of(KIND_LOAD, 0, 32'h8000_0000));
    send_item(item_of(KIND_LOAD, 1, -1));
    send_item(item_of(KIND_LOAD, 2, 5));
    send_item(item_of(KIND_LOAD, 3, 0));
    send_item(item_of(KIND_LOAD, 4, 5));
    send_item(item_of(KIND_LOAD, 5, 0));
    send_item(item_of(KIND_LOAD, 6, 5));
    send_item(item_of(KIND_LOAD, 7, 32'h7FFF_FFFF));
    // min, then -1, then the 0/0 tie, then the 5/5/5 tie
    repeat (5) send_item(item_of(KIND_TAKE, 0, 0));
    send_item(item_of(KIND_CLEAR, 0, 0));
    send_item(item_of(KIND_TAKE, 0, 0));
    send_item(item_of(KIND_LOAD, 7, 32'h7FFF_FFFF));
    send_item(item_of(KIND_TAKE, 7, 32'h7FFF_FFFF));
    send_item(item_of(KIND_TAKE, 0, 0));

    fill_run();
    drain_results();

    while (items_sent < ITEM_TARGET - CALM_ITEMS) begin
      send_gap_pct = 15 * $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) noise_run();
      else merge_run();
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    calm = 1'b1;
    while (items_sent < ITEM_TARGET) merge_run();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin : sink
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_sent >= 100) begin
        // long back-pressure so the block fills and stalls its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/kwm_pkg.sv
sv/kwm_list_mem.sv
sv/kwm_ptr_file.sv
sv/kwm_min_unit.sv
sv/k_way_sorted_merge.sv
tb/sv/kwm_merge_checker.sv
tb/sv/tb_top.sv
